// File: src/contiguous_fit_allocator_defines.svh
// Assertion macros shared by the allocator sources.
`ifndef CONTIGUOUS_FIT_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_DEFINES_SVH

// The condition must hold at every clock edge out of reset.
`define CFA_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("allocator check failed");

// The consequence must hold in the cycle after the antecedent.
`define CFA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator sequence check failed");

`endif

// File: src/cfa_pkg.sv
package cfa_pkg;

	localparam int ADDR_BITS = 20;
	localparam int ID_W      = 16;
	localparam int SZ_W      = 21;
	localparam int START_W   = 20;
	localparam int IN_W      = 48;
	localparam int OUT_W     = 48;

	localparam logic [SZ_W-1:0] MEM_RESET = 21'd1048576;

	localparam logic [1:0] OP_ALLOC   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_COMPACT = 2'd2;

	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOFIT    = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HSCAN,
		S_ALLOC,
		S_PSCAN,
		S_REL,
		S_PACK,
		S_PACK_END,
		S_RESULT
	} state_t;

endpackage

// File: src/contiguous_fit_allocator.sv
// Contiguous fit allocator. One item on s_tdata asks for an allocation (first, best or worst
// fit over the hole table, ties to the lowest index), a release of the newest region held by
// an id, or a compaction; exactly one result item comes back on m_tdata for every item taken.
// Both tables are newest first. Work is done by compare and add logic stepping through
// the tables under a small sequencer, one entry per cycle, and s_tready is low meanwhile.
// An allocate scans every hole before it updates the tables, a release scans the regions until
// the id is found, and a compact moves every region down before it rebuilds the hole table.
// Table shifts (insert at the head, removal of one entry) act on all entries at once.
// Writing cfg_wdata through cfg_wen sets the managed size (0 reads as 1, values above
// 2^ADDR_BITS are clamped) and reinitialises the tables to one full hole; do so only when idle.
module contiguous_fit_allocator
	import cfa_pkg::*;
#(
	parameter int HOLE_ENTRIES = 16,
	parameter int PART_ENTRIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wen,
	input  logic [SZ_W-1:0]  cfg_wdata,   // managed size in units
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,     // op, owner id, request size, fit mode
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata      // status, region_start, region_length
);

	`include "contiguous_fit_allocator_defines.svh"

	localparam int HIW = $clog2(HOLE_ENTRIES);
	localparam int HCW = $clog2(HOLE_ENTRIES + 1);
	localparam int PIW = $clog2(PART_ENTRIES);
	localparam int PCW = $clog2(PART_ENTRIES + 1);
	localparam logic [32:0] MEM_LIMIT = 33'd1 << ADDR_BITS;

	// Item fields as they arrive.
	logic [1:0]      in_op;
	logic [ID_W-1:0] in_pid;
	logic [SZ_W-1:0] in_size;
	logic [1:0]      in_mode;

	assign in_op   = s_tdata[1:0];
	assign in_pid  = s_tdata[17:2];
	assign in_size = s_tdata[38:18];
	assign in_mode = s_tdata[40:39];

	state_t state_q, state_d;

	logic [SZ_W-1:0]    mem_size_q;
	logic [SZ_W-1:0]    hole_start_q [HOLE_ENTRIES];
	logic [SZ_W-1:0]    hole_len_q   [HOLE_ENTRIES];
	logic [HCW-1:0]     hole_cnt_q;
	logic [ID_W-1:0]    part_id_q    [PART_ENTRIES];
	logic [SZ_W-1:0]    part_start_q [PART_ENTRIES];
	logic [SZ_W-1:0]    part_len_q   [PART_ENTRIES];
	logic [PCW-1:0]     part_cnt_q;

	// Latched request and the scan bookkeeping.
	logic [ID_W-1:0] pid_q;
	logic [SZ_W-1:0] size_q;
	logic [1:0]      mode_q;
	logic [HIW-1:0]  hidx_q;
	logic [PIW-1:0]  pidx_q;
	logic [HIW-1:0]  pick_q;
	logic [SZ_W-1:0] best_q;
	logic            found_q;
	logic [PIW-1:0]  at_q;
	logic [SZ_W:0]   next_q;

	logic [1:0]         res_status_q;
	logic [START_W-1:0] res_start_q;
	logic [SZ_W-1:0]    res_len_q;
	logic               out_valid_q;
	logic [1:0]         out_status_q;
	logic [START_W-1:0] out_start_q;
	logic [SZ_W-1:0]    out_len_q;

	// Compare logic for the hole scan and the id scan.
	logic [SZ_W-1:0] hl_i;
	logic            h_last, p_last, fit_ok, better, p_hit;
	logic [SZ_W-1:0] pick_len, pick_start, rem_len;
	logic            take;

	assign hl_i   = hole_len_q[hidx_q];
	assign h_last = (HCW'(hidx_q) + HCW'(1)) == hole_cnt_q;
	assign p_last = (PCW'(pidx_q) + PCW'(1)) == part_cnt_q;
	assign fit_ok = hl_i >= size_q;
	assign better = !found_q || (mode_q == FIT_BEST && hl_i < best_q)
		|| (mode_q == FIT_WORST && hl_i > best_q);
	assign take   = fit_ok && better;
	assign p_hit  = part_id_q[pidx_q] == pid_q;

	assign pick_len   = hole_len_q[pick_q];
	assign pick_start = hole_start_q[pick_q];
	assign rem_len    = pick_len - size_q;

	// Size register input after clamping.
	logic [SZ_W-1:0] cfg_val;
	always_comb begin
		cfg_val = (cfg_wdata == '0) ? SZ_W'(1) : cfg_wdata;
		if ({12'd0, cfg_val} > MEM_LIMIT) begin
			cfg_val = MEM_LIMIT[SZ_W-1:0];
		end
	end

	logic out_free;
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					if (in_op == OP_ALLOC) begin
						if (part_cnt_q >= PCW'(PART_ENTRIES) || in_size == '0) begin
							state_d = S_RESULT;
						end else if (hole_cnt_q == '0) begin
							state_d = S_ALLOC;
						end else begin
							state_d = S_HSCAN;
						end
					end else if (in_op == OP_RELEASE) begin
						state_d = (part_cnt_q == '0) ? S_RESULT : S_PSCAN;
					end else if (in_op == OP_COMPACT) begin
						if (hole_cnt_q == '0) begin
							state_d = S_RESULT;
						end else begin
							state_d = (part_cnt_q == '0) ? S_PACK_END : S_PACK;
						end
					end else begin
						state_d = S_RESULT;
					end
				end
			end
			S_HSCAN: begin
				if (h_last) state_d = S_ALLOC;
			end
			S_ALLOC:    state_d = S_RESULT;
			S_PSCAN: begin
				if (p_hit) begin
					state_d = S_REL;
				end else if (p_last) begin
					state_d = S_RESULT;
				end
			end
			S_REL:      state_d = S_RESULT;
			S_PACK: begin
				if (p_last) state_d = S_PACK_END;
			end
			S_PACK_END: state_d = S_RESULT;
			S_RESULT: begin
				if (out_free) state_d = S_IDLE;
			end
			default:    state_d = S_IDLE;
		endcase
	end

	// Control, hole table and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_size_q  <= MEM_RESET;
			hole_cnt_q  <= HCW'(1);
			part_cnt_q  <= '0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			for (int j = 0; j < HOLE_ENTRIES; j++) begin
				hole_start_q[j] <= '0;
				hole_len_q[j]   <= (j == 0) ? MEM_RESET : '0;
			end
		end else begin
			// A new result loads the output register; a taken one empties it.
			out_valid_q <= (state_q == S_RESULT && out_free) || (out_valid_q && !m_tready);
			if (cfg_wen) begin
				mem_size_q      <= cfg_val;
				hole_start_q[0] <= '0;
				hole_len_q[0]   <= cfg_val;
				hole_cnt_q      <= HCW'(1);
				part_cnt_q      <= '0;
			end
			case (state_q)
				S_IDLE: begin
					found_q <= 1'b0;
				end
				S_HSCAN: begin
					if (take) begin
						found_q <= 1'b1;
					end
				end
				S_ALLOC: begin
					if (found_q) begin
						part_cnt_q <= part_cnt_q + PCW'(1);
						if (rem_len == '0) begin
							// The hole is used up: close the gap behind it.
							for (int j = 0; j < HOLE_ENTRIES - 1; j++) begin
								if (HIW'(j) >= pick_q) begin
									hole_start_q[j] <= hole_start_q[j+1];
									hole_len_q[j]   <= hole_len_q[j+1];
								end
							end
							hole_cnt_q <= hole_cnt_q - HCW'(1);
						end else begin
							hole_start_q[pick_q] <= pick_start + size_q;
							hole_len_q[pick_q]   <= rem_len;
						end
					end
				end
				S_REL: begin
					if (hole_cnt_q < HCW'(HOLE_ENTRIES)) begin
						for (int j = HOLE_ENTRIES - 1; j > 0; j--) begin
							hole_start_q[j] <= hole_start_q[j-1];
							hole_len_q[j]   <= hole_len_q[j-1];
						end
						hole_start_q[0] <= part_start_q[at_q];
						hole_len_q[0]   <= part_len_q[at_q];
						hole_cnt_q      <= hole_cnt_q + HCW'(1);
						part_cnt_q      <= part_cnt_q - PCW'(1);
					end
				end
				S_PACK_END: begin
					if (next_q >= {1'b0, mem_size_q}) begin
						hole_cnt_q <= '0;
					end else begin
						hole_start_q[0] <= next_q[SZ_W-1:0];
						hole_len_q[0]   <= mem_size_q - next_q[SZ_W-1:0];
						hole_cnt_q      <= HCW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers that need no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				pid_q        <= in_pid;
				size_q       <= in_size;
				mode_q       <= in_mode;
				hidx_q       <= '0;
				pidx_q       <= '0;
				pick_q       <= '0;
				best_q       <= '0;
				next_q       <= '0;
				res_start_q  <= '0;
				res_len_q    <= '0;
				res_status_q <= ST_OK;
				if (in_op == OP_ALLOC) begin
					if (part_cnt_q >= PCW'(PART_ENTRIES)) begin
						res_status_q <= ST_FULL;
					end else if (in_size == '0) begin
						res_status_q <= ST_NOFIT;
					end
				end else if (in_op == OP_RELEASE && part_cnt_q == '0) begin
					res_status_q <= ST_NOTFOUND;
				end
			end
			S_HSCAN: begin
				if (take) begin
					pick_q <= hidx_q;
					best_q <= hl_i;
				end
				hidx_q <= hidx_q + HIW'(1);
			end
			S_ALLOC: begin
				if (found_q) begin
					for (int j = PART_ENTRIES - 1; j > 0; j--) begin
						part_id_q[j]    <= part_id_q[j-1];
						part_start_q[j] <= part_start_q[j-1];
						part_len_q[j]   <= part_len_q[j-1];
					end
					part_id_q[0]    <= pid_q;
					part_start_q[0] <= pick_start;
					part_len_q[0]   <= size_q;
					res_start_q     <= pick_start[START_W-1:0];
					res_len_q       <= size_q;
				end else begin
					res_status_q <= ST_NOFIT;
				end
			end
			S_PSCAN: begin
				at_q   <= pidx_q;
				pidx_q <= pidx_q + PIW'(1);
				if (!p_hit && p_last) res_status_q <= ST_NOTFOUND;
			end
			S_REL: begin
				if (hole_cnt_q >= HCW'(HOLE_ENTRIES)) begin
					res_status_q <= ST_FULL;
				end else begin
					res_start_q <= part_start_q[at_q][START_W-1:0];
					res_len_q   <= part_len_q[at_q];
					for (int j = 0; j < PART_ENTRIES - 1; j++) begin
						if (PIW'(j) >= at_q) begin
							part_id_q[j]    <= part_id_q[j+1];
							part_start_q[j] <= part_start_q[j+1];
							part_len_q[j]   <= part_len_q[j+1];
						end
					end
				end
			end
			S_PACK: begin
				part_start_q[pidx_q] <= next_q[SZ_W-1:0];
				next_q <= next_q + {1'b0, part_len_q[pidx_q]};
				pidx_q <= pidx_q + PIW'(1);
			end
			S_PACK_END: begin
				if (next_q < {1'b0, mem_size_q}) begin
					res_start_q <= next_q[START_W-1:0];
					res_len_q   <= mem_size_q - next_q[SZ_W-1:0];
				end
			end
			S_RESULT: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_start_q  <= res_start_q;
					out_len_q    <= res_len_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_len_q, out_start_q, out_status_q};

	// The counts never pass the table depths.
	`CFA_ASSERT_ALWAYS(a_hole_cnt, hole_cnt_q <= HCW'(HOLE_ENTRIES))
	`CFA_ASSERT_ALWAYS(a_part_cnt, part_cnt_q <= PCW'(PART_ENTRIES))
	// The input closes as soon as an item has been accepted.
	`CFA_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready)

endmodule
